@@ rtl/core/rotation_matrix_builder_defines.svh @@
// Assertion macros for the rotation matrix builder.
// Used by rotation_matrix_builder.sv; needs clk and rst_n in scope.
`ifndef ROTATION_MATRIX_BUILDER_DEFINES_SVH
`define ROTATION_MATRIX_BUILDER_DEFINES_SVH
`ifndef SYNTHESIS
`define RMB_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rotation_matrix_builder: check failed");
`define RMB_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rotation_matrix_builder: check failed");
`else
`define RMB_ASSERT_IMP(name, ante, cons)
`define RMB_ASSERT_NXT(name, ante, cons)
`endif
`endif

@@ rtl/core/rmb_pkg.sv @@
// Shared types, constants and tables for the rotation matrix builder.
// No dependencies.
package rmb_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int CORDIC_LAT   = 6;
    localparam int NORM_LAT     = 27;
    localparam int QUARTER_TURN = 5760;
    localparam int TURN_BIAS    = 46080;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic [1:0] func_t;
    localparam func_t FUNC_X   = 2'd0;
    localparam func_t FUNC_Y   = 2'd1;
    localparam func_t FUNC_Z   = 2'd2;
    localparam func_t FUNC_ANY = 2'd3;

    typedef struct packed {
        func_t              func;
        logic signed [15:0] angle;
        logic signed [15:0] axis_x;
        logic signed [15:0] axis_y;
        logic signed [15:0] axis_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic               zero_axis_error;
    } out_t;

    function automatic logic signed [23:0] atan_step(input int i);
        logic signed [23:0] a;
        case (i)
            0:  a = 24'sd737280;
            1:  a = 24'sd435242;
            2:  a = 24'sd229970;
            3:  a = 24'sd116736;
            4:  a = 24'sd58595;
            5:  a = 24'sd29326;
            6:  a = 24'sd14667;
            7:  a = 24'sd7334;
            8:  a = 24'sd3667;
            9:  a = 24'sd1833;
            10: a = 24'sd917;
            11: a = 24'sd458;
            12: a = 24'sd229;
            13: a = 24'sd115;
            14: a = 24'sd57;
            15: a = 24'sd29;
            default: a = 24'sd0;
        endcase
        return a;
    endfunction

    function automatic logic signed [15:0] clamp_one(input logic signed [23:0] v);
        logic signed [23:0] one;
        one = 24'sd1 <<< FRAC_BITS;
        if (v > one)
            return 16'(one);
        else if (v < -one)
            return 16'(-one);
        return v[15:0];
    endfunction

endpackage

@@ rtl/core/rmb_cordic.sv @@
// Pipelined sine/cosine: angle reduction, 16 CORDIC iterations, rounding.
// Depends on rmb_pkg.
module rmb_cordic
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] angle,
    output logic signed [15:0] cos_q,
    output logic signed [15:0] sin_q
);

    localparam int PER_ST = 4;
    localparam int NUM_ST = rmb_pkg::CORDIC_STEPS / PER_ST;

    logic signed [33:0] x_reg [0:NUM_ST];
    logic signed [33:0] y_reg [0:NUM_ST];
    logic signed [23:0] z_reg [0:NUM_ST];
    logic [1:0]         quad_reg [0:NUM_ST];
    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;

    logic signed [17:0] biased;
    logic [16:0]        v;
    logic [3:0]         q16;
    logic [16:0]        r;

    always_comb
    begin
        biased = {{2{angle[15]}}, angle} + 18'(rmb_pkg::TURN_BIAS);
        v      = biased[16:0];
        q16    = '0;
        for (int k = 1; k <= 13; k++)
        begin
            if (v >= 17'(k * rmb_pkg::QUARTER_TURN))
                q16 = q16 + 4'd1;
        end
        r = v - 17'(q16) * 17'(rmb_pkg::QUARTER_TURN);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= rmb_pkg::CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= 24'({r[12:0], 8'b0});
            quad_reg[0] <= q16[1:0];
        end
    end

    for (genvar st = 0; st < NUM_ST; st++)
    begin : g_iter
        logic signed [33:0] x_next;
        logic signed [33:0] y_next;
        logic signed [23:0] z_next;

        always_comb
        begin
            logic signed [33:0] dx;
            logic signed [33:0] dy;
            x_next = x_reg[st];
            y_next = y_reg[st];
            z_next = z_reg[st];
            for (int k = 0; k < PER_ST; k++)
            begin
                dx = y_next >>> (st * PER_ST + k);
                dy = x_next >>> (st * PER_ST + k);
                if (z_next >= 0)
                begin
                    x_next = x_next - dx;
                    y_next = y_next + dy;
                    z_next = z_next - rmb_pkg::atan_step(st * PER_ST + k);
                end
                else
                begin
                    x_next = x_next + dx;
                    y_next = y_next - dy;
                    z_next = z_next + rmb_pkg::atan_step(st * PER_ST + k);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[st + 1]    <= x_next;
                y_reg[st + 1]    <= y_next;
                z_reg[st + 1]    <= z_next;
                quad_reg[st + 1] <= quad_reg[st];
            end
        end
    end

    logic signed [33:0] xr;
    logic signed [33:0] yr;
    logic signed [15:0] c0;
    logic signed [15:0] s0;
    logic signed [15:0] cos_next;
    logic signed [15:0] sin_next;

    always_comb
    begin
        xr = (x_reg[NUM_ST] + 34'sd32768) >>> 16;
        yr = (y_reg[NUM_ST] + 34'sd32768) >>> 16;
        c0 = rmb_pkg::clamp_one(xr[23:0]);
        s0 = rmb_pkg::clamp_one(yr[23:0]);
        case (quad_reg[NUM_ST])
            2'd0:    begin cos_next = c0;  sin_next = s0;  end
            2'd1:    begin cos_next = -s0; sin_next = c0;  end
            2'd2:    begin cos_next = -c0; sin_next = -s0; end
            default: begin cos_next = s0;  sin_next = -c0; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= cos_next;
            sin_reg <= sin_next;
        end
    end

    assign cos_q = cos_reg;
    assign sin_q = sin_reg;

endmodule

@@ rtl/core/rmb_norm.sv @@
// Pipelined axis normalizer: sum of squares, square root, three dividers.
// Depends on rmb_pkg.
module rmb_norm
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    output logic signed [15:0] ux,
    output logic signed [15:0] uy,
    output logic signed [15:0] uz,
    output logic               zero
);

    localparam int SQ_STEPS  = 30;
    localparam int SQ_ST     = SQ_STEPS / 2;
    localparam int DIV_STEPS = 15;
    localparam int DIV_ST    = (DIV_STEPS + 1) / 2;
    localparam int DIV_SH    = rmb_pkg::FRAC_BITS + 14;

    logic [31:0] sqr_reg [3];
    logic [15:0] mag_a_reg [3];
    logic [2:0]  neg_a_reg;
    logic        zero_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqr_reg[0]   <= 32'(axis_x) * 32'(axis_x);
            sqr_reg[1]   <= 32'(axis_y) * 32'(axis_y);
            sqr_reg[2]   <= 32'(axis_z) * 32'(axis_z);
            mag_a_reg[0] <= axis_x[15] ? 16'(-axis_x) : 16'(axis_x);
            mag_a_reg[1] <= axis_y[15] ? 16'(-axis_y) : 16'(axis_y);
            mag_a_reg[2] <= axis_z[15] ? 16'(-axis_z) : 16'(axis_z);
            neg_a_reg    <= {axis_z[15], axis_y[15], axis_x[15]};
            zero_a_reg   <= (axis_x == '0) && (axis_y == '0) && (axis_z == '0);
        end
    end

    logic [61:0] sq_rem_reg  [0:SQ_ST];
    logic [29:0] sq_root_reg [0:SQ_ST];
    logic [15:0] sq_mag_reg  [0:SQ_ST][3];
    logic [2:0]  sq_neg_reg  [0:SQ_ST];
    logic        sq_zero_reg [0:SQ_ST];

    logic [31:0] n2;

    assign n2 = sqr_reg[0] + sqr_reg[1] + sqr_reg[2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rem_reg[0]  <= {2'b0, n2, 28'b0};
            sq_root_reg[0] <= '0;
            sq_mag_reg[0]  <= mag_a_reg;
            sq_neg_reg[0]  <= neg_a_reg;
            sq_zero_reg[0] <= zero_a_reg;
        end
    end

    for (genvar st = 0; st < SQ_ST; st++)
    begin : g_sqrt
        logic [61:0] rem_next;
        logic [29:0] root_next;

        always_comb
        begin
            logic [61:0] trial;
            rem_next  = sq_rem_reg[st];
            root_next = sq_root_reg[st];
            for (int k = 0; k < 2; k++)
            begin
                trial = (62'(root_next) << (SQ_STEPS - st * 2 - k))
                        + (62'd1 << (2 * (SQ_STEPS - 1 - st * 2 - k)));
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = root_next | (30'd1 << (SQ_STEPS - 1 - st * 2 - k));
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[st + 1]  <= rem_next;
                sq_root_reg[st + 1] <= root_next;
                sq_mag_reg[st + 1]  <= sq_mag_reg[st];
                sq_neg_reg[st + 1]  <= sq_neg_reg[st];
                sq_zero_reg[st + 1] <= sq_zero_reg[st];
            end
        end
    end

    logic [44:0] dv_rem_reg  [0:DIV_ST][3];
    logic [14:0] dv_quo_reg  [0:DIV_ST][3];
    logic [29:0] dv_root_reg [0:DIV_ST];
    logic [2:0]  dv_neg_reg  [0:DIV_ST];
    logic        dv_zero_reg [0:DIV_ST];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                dv_rem_reg[0][c] <= (45'(sq_mag_reg[SQ_ST][c]) << DIV_SH)
                                    + 45'(sq_root_reg[SQ_ST] >> 1);
                dv_quo_reg[0][c] <= '0;
            end
            dv_root_reg[0] <= sq_root_reg[SQ_ST];
            dv_neg_reg[0]  <= sq_neg_reg[SQ_ST];
            dv_zero_reg[0] <= sq_zero_reg[SQ_ST];
        end
    end

    for (genvar st = 0; st < DIV_ST; st++)
    begin : g_div
        logic [44:0] rem_next [3];
        logic [14:0] quo_next [3];

        always_comb
        begin
            logic [44:0] dsr;
            for (int c = 0; c < 3; c++)
            begin
                rem_next[c] = dv_rem_reg[st][c];
                quo_next[c] = dv_quo_reg[st][c];
                for (int k = 0; k < 2; k++)
                begin
                    if (st * 2 + k < DIV_STEPS)
                    begin
                        dsr = 45'(dv_root_reg[st]) << (DIV_STEPS - 1 - st * 2 - k);
                        if (rem_next[c] >= dsr)
                        begin
                            rem_next[c] = rem_next[c] - dsr;
                            quo_next[c] = quo_next[c]
                                          | (15'd1 << (DIV_STEPS - 1 - st * 2 - k));
                        end
                    end
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[st + 1]  <= rem_next;
                dv_quo_reg[st + 1]  <= quo_next;
                dv_root_reg[st + 1] <= dv_root_reg[st];
                dv_neg_reg[st + 1]  <= dv_neg_reg[st];
                dv_zero_reg[st + 1] <= dv_zero_reg[st];
            end
        end
    end

    logic signed [15:0] u_reg [3];
    logic               zero_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                u_reg[c] <= dv_neg_reg[DIV_ST][c] ? -16'(dv_quo_reg[DIV_ST][c])
                                                  : 16'(dv_quo_reg[DIV_ST][c]);
            end
            zero_reg <= dv_zero_reg[DIV_ST];
        end
    end

    assign ux   = u_reg[0];
    assign uy   = u_reg[1];
    assign uz   = u_reg[2];
    assign zero = zero_reg;

endmodule

@@ rtl/core/rotation_matrix_builder.sv @@
// Rotation matrix builder: X/Y/Z and arbitrary-axis 3x3 rotations in Q1.14.
// Depends on rmb_pkg, rmb_cordic, rmb_norm and rotation_matrix_builder_defines.svh.
//
// One item is accepted per cycle while in_ready is high, and each gives one matrix
// after 29 pipeline stages plus the output register; the length is set by the
// normalizer's square-root and divider pipelines, which the sine/cosine
// path is delayed to match. A two-entry output buffer lets the pipeline keep
// running after the consumer stops taking items, until its second entry fills.
`include "rotation_matrix_builder_defines.svh"

module rotation_matrix_builder
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  rmb_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output rmb_pkg::out_t out_data
);

    localparam int VLD_LEN = rmb_pkg::NORM_LAT + 2;
    localparam int CS_DLY  = rmb_pkg::NORM_LAT - rmb_pkg::CORDIC_LAT;

    logic en;
    logic skid_valid_reg;
    logic skid_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    rmb_pkg::out_t out_data_reg;
    rmb_pkg::out_t out_data_next;
    rmb_pkg::out_t skid_data_reg;
    rmb_pkg::out_t skid_data_next;
    logic [VLD_LEN-1:0] vld_reg;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[VLD_LEN-2:0], in_valid};
    end

    logic signed [15:0] cos_c;
    logic signed [15:0] sin_c;
    logic signed [15:0] ux;
    logic signed [15:0] uy;
    logic signed [15:0] uz;
    logic               zero;

    rmb_cordic u_cordic
    (
        .clk   (clk),
        .en    (en),
        .angle (in_data.angle),
        .cos_q (cos_c),
        .sin_q (sin_c)
    );

    rmb_norm u_norm
    (
        .clk    (clk),
        .en     (en),
        .axis_x (in_data.axis_x),
        .axis_y (in_data.axis_y),
        .axis_z (in_data.axis_z),
        .ux     (ux),
        .uy     (uy),
        .uz     (uz),
        .zero   (zero)
    );

    rmb_pkg::func_t     func_reg [0:rmb_pkg::NORM_LAT-1];
    logic signed [15:0] cos_d_reg [0:CS_DLY-1];
    logic signed [15:0] sin_d_reg [0:CS_DLY-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            func_reg[0]  <= in_data.func;
            cos_d_reg[0] <= cos_c;
            sin_d_reg[0] <= sin_c;
            for (int i = 1; i < rmb_pkg::NORM_LAT; i++)
                func_reg[i] <= func_reg[i-1];
            for (int i = 1; i < CS_DLY; i++)
            begin
                cos_d_reg[i] <= cos_d_reg[i-1];
                sin_d_reg[i] <= sin_d_reg[i-1];
            end
        end
    end

    logic signed [17:0] xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg;
    logic signed [17:0] xs1_reg, ys1_reg, zs1_reg;
    logic signed [16:0] t_reg;
    logic signed [15:0] c1_reg, s1_reg;
    rmb_pkg::func_t     func1_reg;
    logic               zero1_reg;

    function automatic logic signed [17:0] qmul16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b);
        logic signed [31:0] p;
        p = a * b;
        p = (p + 32'sd8192) >>> rmb_pkg::FRAC_BITS;
        return p[17:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg    <= qmul16(ux, ux);
            yy_reg    <= qmul16(uy, uy);
            zz_reg    <= qmul16(uz, uz);
            xy_reg    <= qmul16(ux, uy);
            xz_reg    <= qmul16(ux, uz);
            yz_reg    <= qmul16(uy, uz);
            xs1_reg   <= qmul16(ux, sin_d_reg[CS_DLY-1]);
            ys1_reg   <= qmul16(uy, sin_d_reg[CS_DLY-1]);
            zs1_reg   <= qmul16(uz, sin_d_reg[CS_DLY-1]);
            t_reg     <= (17'sd1 <<< rmb_pkg::FRAC_BITS) - 17'(cos_d_reg[CS_DLY-1]);
            c1_reg    <= cos_d_reg[CS_DLY-1];
            s1_reg    <= sin_d_reg[CS_DLY-1];
            func1_reg <= func_reg[rmb_pkg::NORM_LAT-1];
            zero1_reg <= zero;
        end
    end

    function automatic logic signed [20:0] qmul_t(input logic signed [17:0] a,
                                                  input logic signed [16:0] t);
        logic signed [35:0] p;
        p = a * t;
        p = (p + 36'sd8192) >>> rmb_pkg::FRAC_BITS;
        return p[20:0];
    endfunction

    logic signed [20:0] xxt_reg, yyt_reg, zzt_reg, xyt_reg, xzt_reg, yzt_reg;
    logic signed [17:0] xs2_reg, ys2_reg, zs2_reg;
    logic signed [15:0] c2_reg, s2_reg;
    rmb_pkg::func_t     func2_reg;
    logic               zero2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xxt_reg   <= qmul_t(xx_reg, t_reg);
            yyt_reg   <= qmul_t(yy_reg, t_reg);
            zzt_reg   <= qmul_t(zz_reg, t_reg);
            xyt_reg   <= qmul_t(xy_reg, t_reg);
            xzt_reg   <= qmul_t(xz_reg, t_reg);
            yzt_reg   <= qmul_t(yz_reg, t_reg);
            xs2_reg   <= xs1_reg;
            ys2_reg   <= ys1_reg;
            zs2_reg   <= zs1_reg;
            c2_reg    <= c1_reg;
            s2_reg    <= s1_reg;
            func2_reg <= func1_reg;
            zero2_reg <= zero1_reg;
        end
    end

    rmb_pkg::out_t res;
    logic signed [15:0] one16;
    logic signed [23:0] c24;

    always_comb
    begin
        one16 = 16'sd1 <<< rmb_pkg::FRAC_BITS;
        c24   = 24'(c2_reg);
        res   = '0;
        case (func2_reg)
            rmb_pkg::FUNC_X:
            begin
                res.m00 = one16;
                res.m11 = c2_reg;
                res.m12 = s2_reg;
                res.m21 = -s2_reg;
                res.m22 = c2_reg;
            end
            rmb_pkg::FUNC_Y:
            begin
                res.m00 = c2_reg;
                res.m02 = -s2_reg;
                res.m11 = one16;
                res.m20 = s2_reg;
                res.m22 = c2_reg;
            end
            rmb_pkg::FUNC_Z:
            begin
                res.m00 = c2_reg;
                res.m01 = s2_reg;
                res.m10 = -s2_reg;
                res.m11 = c2_reg;
                res.m22 = one16;
            end
            default:
            begin
                if (zero2_reg)
                    res.zero_axis_error = 1'b1;
                else
                begin
                    res.m00 = rmb_pkg::clamp_one(c24 + 24'(xxt_reg));
                    res.m01 = rmb_pkg::clamp_one(24'(xyt_reg) - 24'(zs2_reg));
                    res.m02 = rmb_pkg::clamp_one(24'(xzt_reg) + 24'(ys2_reg));
                    res.m10 = rmb_pkg::clamp_one(24'(xyt_reg) + 24'(zs2_reg));
                    res.m11 = rmb_pkg::clamp_one(c24 + 24'(yyt_reg));
                    res.m12 = rmb_pkg::clamp_one(24'(yzt_reg) - 24'(xs2_reg));
                    res.m20 = rmb_pkg::clamp_one(24'(xzt_reg) - 24'(ys2_reg));
                    res.m21 = rmb_pkg::clamp_one(24'(yzt_reg) + 24'(xs2_reg));
                    res.m22 = rmb_pkg::clamp_one(c24 + 24'(zzt_reg));
                end
            end
        endcase
    end

    logic last_valid;

    assign last_valid = vld_reg[VLD_LEN-1] && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (last_valid)
                out_data_next = res;
            else
                out_valid_next = 1'b0;
        end
        else if (!out_valid_reg)
        begin
            if (last_valid)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
        else if (last_valid)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `RMB_ASSERT_IMP(a_skid_has_out, skid_valid_reg, out_valid_reg)
    `RMB_ASSERT_NXT(a_hold_to_skid, out_valid_reg && !out_ready && last_valid, skid_valid_reg)
    `RMB_ASSERT_NXT(a_skid_drain, skid_valid_reg && out_ready, out_valid_reg && !skid_valid_reg)

endmodule
